/* hw/rtl/ray_box_slab_hit_top_defines.svh */
// Assertion macros for the checker file of the ray/box block.
`ifndef RAY_BOX_SLAB_HIT_TOP_DEFINES_SVH
`define RAY_BOX_SLAB_HIT_TOP_DEFINES_SVH

// General property, checked on every rising clock edge outside reset.
`define RBSH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A result word that waits on a stalled sink keeps the given signal stable.
`define RBSH_HOLD(lbl, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        out_valid && !out_ready |=> $stable(sig)) else $error(msg);

`endif

/* hw/rtl/rbsh_pkg.sv */
package rbsh_pkg;

    typedef logic signed [31:0] fx_t;
    typedef logic [30:0]        ent_t;
    typedef logic [2:0]         face_t;

    localparam face_t FACE_NEG_X = 3'd0;
    localparam face_t FACE_POS_X = 3'd1;
    localparam face_t FACE_NEG_Y = 3'd2;
    localparam face_t FACE_POS_Y = 3'd3;
    localparam face_t FACE_NEG_Z = 3'd4;
    localparam face_t FACE_POS_Z = 3'd5;

    localparam face_t FACE_LO [3] = '{FACE_NEG_X, FACE_NEG_Y, FACE_NEG_Z};
    localparam face_t FACE_HI [3] = '{FACE_POS_X, FACE_POS_Y, FACE_POS_Z};

    localparam ent_t ENT_MAX = 31'h7FFF_FFFF;
    localparam fx_t  FX_MAX  = 32'sh7FFF_FFFF;
    localparam fx_t  FX_MIN  = 32'sh8000_0000;

endpackage

/* hw/rtl/rbsh_if.sv */
interface rbsh_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] parallel_threshold;

    modport source (output valid, output parallel_threshold, input ready);
    modport sink   (input valid, input parallel_threshold, output ready);
endinterface

interface rbsh_ray_if;
    logic         valid;
    logic         ready;
    rbsh_pkg::fx_t origin_x;
    rbsh_pkg::fx_t origin_y;
    rbsh_pkg::fx_t origin_z;
    rbsh_pkg::fx_t dir_x;
    rbsh_pkg::fx_t dir_y;
    rbsh_pkg::fx_t dir_z;
    rbsh_pkg::fx_t corner_a_x;
    rbsh_pkg::fx_t corner_a_y;
    rbsh_pkg::fx_t corner_a_z;
    rbsh_pkg::fx_t corner_b_x;
    rbsh_pkg::fx_t corner_b_y;
    rbsh_pkg::fx_t corner_b_z;

    modport source (output valid, output origin_x, output origin_y, output origin_z,
                    output dir_x, output dir_y, output dir_z,
                    output corner_a_x, output corner_a_y, output corner_a_z,
                    output corner_b_x, output corner_b_y, output corner_b_z,
                    input ready);
    modport sink   (input valid, input origin_x, input origin_y, input origin_z,
                    input dir_x, input dir_y, input dir_z,
                    input corner_a_x, input corner_a_y, input corner_a_z,
                    input corner_b_x, input corner_b_y, input corner_b_z,
                    output ready);
endinterface

interface rbsh_res_if;
    logic           valid;
    logic           ready;
    logic           hit;
    rbsh_pkg::ent_t entry_distance;
    rbsh_pkg::fx_t  hit_pos_x;
    rbsh_pkg::fx_t  hit_pos_y;
    rbsh_pkg::fx_t  hit_pos_z;
    rbsh_pkg::face_t face_code;

    modport source (output valid, output hit, output entry_distance,
                    output hit_pos_x, output hit_pos_y, output hit_pos_z,
                    output face_code, input ready);
    modport sink   (input valid, input hit, input entry_distance,
                    input hit_pos_x, input hit_pos_y, input hit_pos_z,
                    input face_code, output ready);
endinterface

/* hw/rtl/rbsh_div.sv */
// Unsigned restoring divider, one quotient bit per pipeline stage.
module rbsh_div #(
    parameter int NB = 48
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NB-1:0] num,
    input  logic [31:0]   den,
    output logic [NB-1:0] quo
);

    logic [31:0]   r_reg [NB];
    logic [31:0]   d_reg [NB];
    logic [NB-1:0] n_reg [NB];
    logic [NB-1:0] q_reg [NB];

    for (genvar k = 0; k < NB; k++) begin : g_stage
        logic [31:0]   r_in;
        logic [31:0]   d_in;
        logic [NB-1:0] n_in;
        logic [NB-1:0] q_in;
        logic [32:0]   rs;
        logic [32:0]   diff;
        logic          ge;
        logic [31:0]   r_next;

        if (k == 0) begin : g_first
            assign r_in = '0;
            assign d_in = den;
            assign n_in = num;
            assign q_in = '0;
        end
        else begin : g_rest
            assign r_in = r_reg[k-1];
            assign d_in = d_reg[k-1];
            assign n_in = n_reg[k-1];
            assign q_in = q_reg[k-1];
        end

        // The partial remainder stays below the divisor, so the shifted value
        // fits 33 bits and the borrow shows in the top bit of the difference.
        assign rs     = {r_in, n_in[NB-1]};
        assign diff   = rs - {1'b0, d_in};
        assign ge     = !diff[32];
        assign r_next = ge ? diff[31:0] : rs[31:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k] <= r_next;
                d_reg[k] <= d_in;
                n_reg[k] <= {n_in[NB-2:0], 1'b0};
                q_reg[k] <= {q_in[NB-2:0], ge};
            end
        end
    end

    assign quo = q_reg[NB-1];

endmodule

/* hw/rtl/ray_box_slab_hit_top.sv */
// Ray versus axis-aligned box, slab method, in signed fixed point with FRAC_BITS fraction
// bits. The block takes one ray/box word per cycle while it is not stalled and returns one
// result word for each, in order. Most of the pipeline is the six slab divisions, each a
// restoring divider that resolves one quotient bit per stage over 32 + FRAC_BITS stages;
// the rest is sorting, sign handling, min/max reduction, the position multiply and the
// nearest-face search. The pipeline moves as a whole: ray_box.ready follows result.ready
// whenever a result word is waiting, and no word is dropped or repeated across a stall.
// The user is to write the threshold register through cfg only while the block is idle;
// the block does not enforce this. The threshold register reads as zero after reset.
module ray_box_slab_hit_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    rbsh_cfg_if.sink    cfg,
    rbsh_ray_if.sink    ray_box,
    rbsh_res_if.source  result
);

    localparam int NB = 32 + FRAC_BITS;
    localparam int QW = NB + 1;

    typedef logic signed [QW-1:0] tq_t;
    typedef logic signed [32:0]   dif_t;

    localparam tq_t T_MAX  = tq_t'({1'b0, {NB{1'b1}}});
    localparam tq_t T_ZERO = '0;

    typedef struct {
        rbsh_pkg::fx_t org [3];
        rbsh_pkg::fx_t dir [3];
        rbsh_pkg::fx_t lo  [3];
        rbsh_pkg::fx_t hi  [3];
    } side_t;

    typedef struct {
        side_t      side;
        logic [2:0] par;
        logic       pmiss;
        logic [5:0] neg;
    } mid_t;

    logic        adv;
    logic [15:0] thr_reg;

    // Valid bits.
    logic          v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic          v8_reg, v9_reg, v10_reg, v11_reg, v12_reg, v13_reg, vo_reg;
    logic [NB-1:0] vd_reg;

    // Front end.
    rbsh_pkg::fx_t org_in [3];
    rbsh_pkg::fx_t dir_in [3];
    rbsh_pkg::fx_t ca_in  [3];
    rbsh_pkg::fx_t cb_in  [3];
    side_t         s1_reg;
    side_t         s2_reg;
    dif_t          dlo2_reg  [3];
    dif_t          dhi2_reg  [3];
    logic [31:0]   adir2_reg [3];
    logic [2:0]    dneg2_reg;
    logic [2:0]    pm2_reg;

    logic [2:0]    par3_next;
    dif_t          mlo3_next [3];
    dif_t          mhi3_next [3];
    mid_t          m3_reg;
    logic [NB-1:0] num3_reg [6];
    logic [31:0]   den3_reg [3];

    // Divider side channel.
    mid_t          dp_reg [NB];
    logic [NB-1:0] quo [6];

    // Back end.
    tq_t           t4_next [6];
    tq_t           t4_reg  [6];
    mid_t          m4_reg;
    tq_t           near5_next [3];
    tq_t           far5_next  [3];
    tq_t           near5_reg  [3];
    tq_t           far5_reg   [3];
    side_t         side5_reg, side6_reg, side7_reg, side8_reg, side9_reg;
    logic          pmiss5_reg, pmiss6_reg, pmiss7_reg;
    tq_t           e01_6_reg, e2z_6_reg, x01_6_reg, f2_6_reg;
    tq_t           enter7_reg, exit7_reg;
    logic          hit8_reg, hit9_reg, hit10_reg, hit11_reg, hit12_reg, hit13_reg;
    rbsh_pkg::ent_t te8_reg, te9_reg, te10_reg, te11_reg, te12_reg, te13_reg;
    logic signed [63:0] prod9_next [3];
    logic signed [63:0] prod9_reg  [3];
    logic signed [63:0] sum10_next [3];
    rbsh_pkg::fx_t pos10_next [3];
    rbsh_pkg::fx_t pos10_reg  [3];
    rbsh_pkg::fx_t pos11_reg  [3];
    rbsh_pkg::fx_t pos12_reg  [3];
    rbsh_pkg::fx_t pos13_reg  [3];
    rbsh_pkg::fx_t lo10_reg   [3];
    rbsh_pkg::fx_t hi10_reg   [3];
    dif_t          dv11_next  [6];
    logic [32:0]   d11_next   [6];
    logic [32:0]   d11_reg    [6];
    logic [32:0]   bd12_reg   [3];
    rbsh_pkg::face_t bf12_reg [3];
    logic [32:0]   bd13_reg, dz13_reg;
    rbsh_pkg::face_t bf13_reg, fz13_reg;

    // Output register.
    logic            o_hit_reg;
    rbsh_pkg::ent_t  o_ent_reg;
    rbsh_pkg::fx_t   o_pos_reg [3];
    rbsh_pkg::face_t o_face_reg;
    rbsh_pkg::face_t face_next;

    assign adv           = !vo_reg || result.ready;
    assign ray_box.ready = adv;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg.valid)
        begin
            thr_reg <= cfg.parallel_threshold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            vd_reg  <= '0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
            v13_reg <= 1'b0;
            vo_reg  <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg  <= ray_box.valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            vd_reg  <= {vd_reg[NB-2:0], v3_reg};
            v4_reg  <= vd_reg[NB-1];
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
            v12_reg <= v11_reg;
            v13_reg <= v12_reg;
            vo_reg  <= v13_reg;
        end
    end

    assign org_in = '{ray_box.origin_x, ray_box.origin_y, ray_box.origin_z};
    assign dir_in = '{ray_box.dir_x, ray_box.dir_y, ray_box.dir_z};
    assign ca_in  = '{ray_box.corner_a_x, ray_box.corner_a_y, ray_box.corner_a_z};
    assign cb_in  = '{ray_box.corner_b_x, ray_box.corner_b_y, ray_box.corner_b_z};

    // Stage 1: sort the corners into lower and upper bounds.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                s1_reg.org[ax] <= org_in[ax];
                s1_reg.dir[ax] <= dir_in[ax];
                s1_reg.lo[ax]  <= (ca_in[ax] < cb_in[ax]) ? ca_in[ax] : cb_in[ax];
                s1_reg.hi[ax]  <= (ca_in[ax] < cb_in[ax]) ? cb_in[ax] : ca_in[ax];
            end
        end
    end

    // Stage 2: slab offsets, direction magnitude, whether the origin lies outside each slab.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg <= s1_reg;
            for (int ax = 0; ax < 3; ax++)
            begin
                dlo2_reg[ax]  <= {s1_reg.lo[ax][31], s1_reg.lo[ax]}
                                 - {s1_reg.org[ax][31], s1_reg.org[ax]};
                dhi2_reg[ax]  <= {s1_reg.hi[ax][31], s1_reg.hi[ax]}
                                 - {s1_reg.org[ax][31], s1_reg.org[ax]};
                adir2_reg[ax] <= s1_reg.dir[ax][31] ? 32'(-s1_reg.dir[ax])
                                                    : 32'(s1_reg.dir[ax]);
                dneg2_reg[ax] <= s1_reg.dir[ax][31];
                pm2_reg[ax]   <= (s1_reg.org[ax] < s1_reg.lo[ax])
                                 || (s1_reg.org[ax] > s1_reg.hi[ax]);
            end
        end
    end

    // Stage 3: parallel test and divider operands as sign and magnitude.
    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            par3_next[ax] = adir2_reg[ax] <= {16'd0, thr_reg};
            mlo3_next[ax] = dlo2_reg[ax][32] ? -dlo2_reg[ax] : dlo2_reg[ax];
            mhi3_next[ax] = dhi2_reg[ax][32] ? -dhi2_reg[ax] : dhi2_reg[ax];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_reg.side  <= s2_reg;
            m3_reg.par   <= par3_next;
            m3_reg.pmiss <= |(par3_next & pm2_reg);
            for (int ax = 0; ax < 3; ax++)
            begin
                num3_reg[2*ax]     <= {mlo3_next[ax][31:0], {FRAC_BITS{1'b0}}};
                num3_reg[2*ax+1]   <= {mhi3_next[ax][31:0], {FRAC_BITS{1'b0}}};
                m3_reg.neg[2*ax]   <= dlo2_reg[ax][32] ^ dneg2_reg[ax];
                m3_reg.neg[2*ax+1] <= dhi2_reg[ax][32] ^ dneg2_reg[ax];
                den3_reg[ax]       <= adir2_reg[ax];
            end
        end
    end

    for (genvar i = 0; i < 6; i++) begin : g_lane
        rbsh_div #(
            .NB(NB)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num (num3_reg[i]),
            .den (den3_reg[i >> 1]),
            .quo (quo[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dp_reg[0] <= m3_reg;
            for (int k = 1; k < NB; k++)
            begin
                dp_reg[k] <= dp_reg[k-1];
            end
        end
    end

    // Stage 4: restore the sign of each slab distance.
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            t4_next[i] = dp_reg[NB-1].neg[i] ? -tq_t'({1'b0, quo[i]})
                                             : tq_t'({1'b0, quo[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t4_reg <= t4_next;
            m4_reg <= dp_reg[NB-1];
        end
    end

    // Stage 5: near and far distance per axis; a parallel axis adds no bound.
    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            if (m4_reg.par[ax])
            begin
                near5_next[ax] = T_ZERO;
                far5_next[ax]  = T_MAX;
            end
            else if (t4_reg[2*ax] > t4_reg[2*ax+1])
            begin
                near5_next[ax] = t4_reg[2*ax+1];
                far5_next[ax]  = t4_reg[2*ax];
            end
            else
            begin
                near5_next[ax] = t4_reg[2*ax];
                far5_next[ax]  = t4_reg[2*ax+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            near5_reg  <= near5_next;
            far5_reg   <= far5_next;
            side5_reg  <= m4_reg.side;
            pmiss5_reg <= m4_reg.pmiss;
        end
    end

    // Stages 6 and 7: entry is the largest near distance (at least zero),
    // exit the smallest far distance.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e01_6_reg  <= (near5_reg[1] > near5_reg[0]) ? near5_reg[1] : near5_reg[0];
            e2z_6_reg  <= (near5_reg[2] > T_ZERO) ? near5_reg[2] : T_ZERO;
            x01_6_reg  <= (far5_reg[1] < far5_reg[0]) ? far5_reg[1] : far5_reg[0];
            f2_6_reg   <= far5_reg[2];
            side6_reg  <= side5_reg;
            pmiss6_reg <= pmiss5_reg;

            enter7_reg <= (e2z_6_reg > e01_6_reg) ? e2z_6_reg : e01_6_reg;
            exit7_reg  <= (f2_6_reg < x01_6_reg) ? f2_6_reg : x01_6_reg;
            side7_reg  <= side6_reg;
            pmiss7_reg <= pmiss6_reg;
        end
    end

    // Stage 8: hit decision and saturated entry distance.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit8_reg  <= !pmiss7_reg && !(exit7_reg < enter7_reg);
            te8_reg   <= (|enter7_reg[QW-1:31]) ? rbsh_pkg::ENT_MAX : enter7_reg[30:0];
            side8_reg <= side7_reg;
        end
    end

    // Stage 9: distance times direction.
    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            prod9_next[ax] = $signed({1'b0, te8_reg}) * side8_reg.dir[ax];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod9_reg <= prod9_next;
            hit9_reg  <= hit8_reg;
            te9_reg   <= te8_reg;
            side9_reg <= side8_reg;
        end
    end

    // Stage 10: position, with the product floored to the fixed-point scale and the sum saturated.
    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            sum10_next[ax] = 64'(side9_reg.org[ax]) + (prod9_reg[ax] >>> FRAC_BITS);
            if (sum10_next[ax][63:31] == {33{sum10_next[ax][63]}})
            begin
                pos10_next[ax] = sum10_next[ax][31:0];
            end
            else
            begin
                pos10_next[ax] = sum10_next[ax][63] ? rbsh_pkg::FX_MIN : rbsh_pkg::FX_MAX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos10_reg <= pos10_next;
            lo10_reg  <= side9_reg.lo;
            hi10_reg  <= side9_reg.hi;
            hit10_reg <= hit9_reg;
            te10_reg  <= te9_reg;
        end
    end

    // Stage 11: distance from the position to each of the six faces.
    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            dv11_next[2*ax]   = {pos10_reg[ax][31], pos10_reg[ax]}
                                - {lo10_reg[ax][31], lo10_reg[ax]};
            dv11_next[2*ax+1] = {pos10_reg[ax][31], pos10_reg[ax]}
                                - {hi10_reg[ax][31], hi10_reg[ax]};
        end
        for (int f = 0; f < 6; f++)
        begin
            d11_next[f] = dv11_next[f][32] ? 33'(-dv11_next[f]) : 33'(dv11_next[f]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d11_reg   <= d11_next;
            pos11_reg <= pos10_reg;
            hit11_reg <= hit10_reg;
            te11_reg  <= te10_reg;
        end
    end

    // Stages 12 to 14: nearest face; a later face wins only when strictly closer.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                if (d11_reg[2*ax+1] < d11_reg[2*ax])
                begin
                    bd12_reg[ax] <= d11_reg[2*ax+1];
                    bf12_reg[ax] <= rbsh_pkg::FACE_HI[ax];
                end
                else
                begin
                    bd12_reg[ax] <= d11_reg[2*ax];
                    bf12_reg[ax] <= rbsh_pkg::FACE_LO[ax];
                end
            end
            pos12_reg <= pos11_reg;
            hit12_reg <= hit11_reg;
            te12_reg  <= te11_reg;

            bd13_reg  <= (bd12_reg[1] < bd12_reg[0]) ? bd12_reg[1] : bd12_reg[0];
            bf13_reg  <= (bd12_reg[1] < bd12_reg[0]) ? bf12_reg[1] : bf12_reg[0];
            dz13_reg  <= bd12_reg[2];
            fz13_reg  <= bf12_reg[2];
            pos13_reg <= pos12_reg;
            hit13_reg <= hit12_reg;
            te13_reg  <= te12_reg;
        end
    end

    assign face_next = (dz13_reg < bd13_reg) ? fz13_reg : bf13_reg;

    // A miss reports every field as zero.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_hit_reg  <= hit13_reg;
            o_ent_reg  <= hit13_reg ? te13_reg : '0;
            o_face_reg <= hit13_reg ? face_next : rbsh_pkg::FACE_NEG_X;
            for (int ax = 0; ax < 3; ax++)
            begin
                o_pos_reg[ax] <= hit13_reg ? pos13_reg[ax] : '0;
            end
        end
    end

    assign result.valid          = vo_reg;
    assign result.hit            = o_hit_reg;
    assign result.entry_distance = o_ent_reg;
    assign result.hit_pos_x      = o_pos_reg[0];
    assign result.hit_pos_y      = o_pos_reg[1];
    assign result.hit_pos_z      = o_pos_reg[2];
    assign result.face_code      = o_face_reg;

endmodule

/* hw/rtl/rbsh_chk.sv */
module rbsh_chk (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic                  out_hit,
    input logic [30:0]           out_entry,
    input logic signed [31:0]    out_pos_x,
    input logic signed [31:0]    out_pos_y,
    input logic signed [31:0]    out_pos_z,
    input logic [2:0]            out_face
);

`include "ray_box_slab_hit_top_defines.svh"

    `RBSH_ASSERT(a_valid_hold, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")
    `RBSH_HOLD(a_word_hold, {out_hit, out_entry, out_pos_x, out_pos_y, out_pos_z, out_face}, "result word changed while stalled")
    `RBSH_ASSERT(a_miss_zero, out_valid && !out_hit |-> out_entry == 31'd0 && out_pos_x == 32'sd0 && out_pos_y == 32'sd0 && out_pos_z == 32'sd0 && out_face == 3'd0, "miss word carries nonzero fields")
    `RBSH_ASSERT(a_ready_free, !out_valid |-> in_ready, "input stalled with empty output register")

endmodule

bind ray_box_slab_hit_top rbsh_chk u_rbsh_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (ray_box.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_hit   (result.hit),
    .out_entry (result.entry_distance),
    .out_pos_x (result.hit_pos_x),
    .out_pos_y (result.hit_pos_y),
    .out_pos_z (result.hit_pos_z),
    .out_face  (result.face_code)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAC       = 16;
    localparam int LATENCY    = FRAC + 46;
    localparam int CYCLE_MAX  = 2000000;

    typedef struct {
        rbsh_pkg::fx_t org [3];
        rbsh_pkg::fx_t dir [3];
        rbsh_pkg::fx_t ca  [3];
        rbsh_pkg::fx_t cb  [3];
    } ray_box_t;

    typedef struct {
        logic            hit;
        rbsh_pkg::ent_t  entry;
        rbsh_pkg::fx_t   pos [3];
        rbsh_pkg::face_t face;
    } slab_hit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rbsh_cfg_if cfg ();
    rbsh_ray_if ray_box ();
    rbsh_res_if result ();

    ray_box_slab_hit_top #(.FRAC_BITS(FRAC)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .ray_box (ray_box),
        .result  (result)
    );

    always #4 clk = ~clk;

    logic [15:0] threshold = '0;
    slab_hit_t   hits_due [$];
    int          src_idle = 0;
    int          snk_idle = 0;
    int          errors = 0;
    int          n_items = 0;
    int          n_hits = 0;
    int          cycles = 0;

    function automatic slab_hit_t predict_hit(ray_box_t r);
        slab_hit_t res;
        longint o [3], d [3], lo [3], hi [3], p [3];
        longint a, b, t0, t1, tmp, t_in, t_out, best_d, dd;
        bit ok;
        int best;
        t_in = 0;
        t_out = 64'sh7FFF_FFFF_FFFF_FFFF;
        ok = 1'b1;
        res.hit = 1'b0;
        res.entry = '0;
        res.face = rbsh_pkg::FACE_NEG_X;
        for (int ax = 0; ax < 3; ax++)
        begin
            res.pos[ax] = '0;
            o[ax] = r.org[ax];
            d[ax] = r.dir[ax];
            a = r.ca[ax];
            b = r.cb[ax];
            lo[ax] = (a < b) ? a : b;
            hi[ax] = (a < b) ? b : a;
        end
        for (int ax = 0; ax < 3 && ok; ax++)
        begin
            if ((d[ax] < 0 ? -d[ax] : d[ax]) <= longint'(threshold))
            begin
                if (o[ax] < lo[ax] || o[ax] > hi[ax])
                    ok = 1'b0;
            end
            else
            begin
                t0 = ((lo[ax] - o[ax]) <<< FRAC) / d[ax];
                t1 = ((hi[ax] - o[ax]) <<< FRAC) / d[ax];
                if (t0 > t1)
                begin
                    tmp = t0;
                    t0 = t1;
                    t1 = tmp;
                end
                if (t0 > t_in)
                    t_in = t0;
                if (t1 < t_out)
                    t_out = t1;
                if (t_out < t_in)
                    ok = 1'b0;
            end
        end
        if (!ok)
            return res;
        if (t_in > 64'sh7FFF_FFFF)
            t_in = 64'sh7FFF_FFFF;
        for (int ax = 0; ax < 3; ax++)
        begin
            p[ax] = o[ax] + ((t_in * d[ax]) >>> FRAC);
            if (p[ax] > longint'(rbsh_pkg::FX_MAX))
                p[ax] = rbsh_pkg::FX_MAX;
            if (p[ax] < longint'(rbsh_pkg::FX_MIN))
                p[ax] = rbsh_pkg::FX_MIN;
            res.pos[ax] = p[ax][31:0];
        end
        // Strict compare keeps the earliest face in -x,+x,-y,+y,-z,+z order on ties.
        best = 0;
        best_d = p[0] - lo[0];
        best_d = best_d < 0 ? -best_d : best_d;
        for (int f = 1; f < 6; f++)
        begin
            dd = p[f >> 1] - ((f & 1) ? hi[f >> 1] : lo[f >> 1]);
            dd = dd < 0 ? -dd : dd;
            if (dd < best_d)
            begin
                best_d = dd;
                best = f;
            end
        end
        res.face = (best & 1) ? rbsh_pkg::FACE_HI[best >> 1] : rbsh_pkg::FACE_LO[best >> 1];
        res.hit = 1'b1;
        res.entry = t_in[30:0];
        return res;
    endfunction

    task automatic send_word(ray_box_t r);
        if ($urandom_range(99) < src_idle)
        begin
            ray_box.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle);
        end
        ray_box.valid      <= 1'b1;
        ray_box.origin_x   <= r.org[0];
        ray_box.origin_y   <= r.org[1];
        ray_box.origin_z   <= r.org[2];
        ray_box.dir_x      <= r.dir[0];
        ray_box.dir_y      <= r.dir[1];
        ray_box.dir_z      <= r.dir[2];
        ray_box.corner_a_x <= r.ca[0];
        ray_box.corner_a_y <= r.ca[1];
        ray_box.corner_a_z <= r.ca[2];
        ray_box.corner_b_x <= r.cb[0];
        ray_box.corner_b_y <= r.cb[1];
        ray_box.corner_b_z <= r.cb[2];
        do
            @(posedge clk);
        while (!ray_box.ready);
        hits_due.push_back(predict_hit(r));
        n_items++;
    endtask

    task automatic drain();
        ray_box.valid <= 1'b0;
        while (hits_due.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_threshold(logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.parallel_threshold <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        threshold = value;
    endtask

    function automatic ray_box_t make_word(
        rbsh_pkg::fx_t ox, rbsh_pkg::fx_t oy, rbsh_pkg::fx_t oz,
        rbsh_pkg::fx_t dx, rbsh_pkg::fx_t dy, rbsh_pkg::fx_t dz,
        rbsh_pkg::fx_t ax, rbsh_pkg::fx_t ay, rbsh_pkg::fx_t az,
        rbsh_pkg::fx_t bx, rbsh_pkg::fx_t by, rbsh_pkg::fx_t bz);
        ray_box_t r;
        r.org = '{ox, oy, oz};
        r.dir = '{dx, dy, dz};
        r.ca  = '{ax, ay, az};
        r.cb  = '{bx, by, bz};
        return r;
    endfunction

    // Coordinates in a modest range, so that most rays actually reach the box.
    function automatic rbsh_pkg::fx_t near_val(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    function automatic ray_box_t random_word();
        ray_box_t r;
        int mode;
        rbsh_pkg::fx_t c;
        mode = $urandom_range(9);
        for (int ax = 0; ax < 3; ax++)
        begin
            if (mode < 2)
            begin
                r.org[ax] = $urandom;
                r.dir[ax] = $urandom;
                r.ca[ax]  = $urandom;
                r.cb[ax]  = $urandom;
            end
            else
            begin
                c = near_val(32'h0040_0000);
                r.ca[ax] = c + near_val(32'h0008_0000);
                r.cb[ax] = c + near_val(32'h0008_0000);
                r.org[ax] = near_val(32'h0080_0000);
                // Aim the ray roughly at the box center, sometimes away from it.
                r.dir[ax] = (c - r.org[ax]) >>> $urandom_range(8);
                if (mode == 9)
                    r.dir[ax] = -r.dir[ax];
                if ($urandom_range(7) == 0)
                    r.dir[ax] = near_val(32'h0001_0000);
                if ($urandom_range(11) == 0)
                    r.dir[ax] = '0;
            end
        end
        return r;
    endfunction

    task automatic test_directed();
        rbsh_pkg::fx_t one;
        rbsh_pkg::fx_t fmax;
        rbsh_pkg::fx_t fmin;
        one = 32'sh0001_0000;
        fmax = rbsh_pkg::FX_MAX;
        fmin = rbsh_pkg::FX_MIN;
        // Origin inside the box gives distance zero.
        send_word(make_word(0, 0, 0, one, one, one, -one, -one, -one, one, one, one));
        // Straight hit on each face, with corners in swapped order on some.
        send_word(make_word(-5 * one, 0, 0, one, 0, 0, one, -one, -one, -one, one, one));
        send_word(make_word(5 * one, 0, 0, -one, 0, 0, -one, -one, -one, one, one, one));
        send_word(make_word(0, -5 * one, 0, 0, one, 0, -one, one, -one, one, -one, one));
        send_word(make_word(0, 5 * one, 0, 0, -one, 0, -one, -one, -one, one, one, one));
        send_word(make_word(0, 0, -5 * one, 0, 0, one, -one, -one, one, one, one, -one));
        send_word(make_word(0, 0, 5 * one, 0, 0, -one, -one, -one, -one, one, one, one));
        // Box behind the ray.
        send_word(make_word(-5 * one, 0, 0, -one, 0, 0, -one, -one, -one, one, one, one));
        // Parallel axes, origin outside and inside the slab.
        send_word(make_word(-5 * one, 3 * one, 0, one, 0, 0, -one, -one, -one, one, one, one));
        send_word(make_word(-5 * one, 0, 0, one, 0, 0, -one, -one, -one, one, one, one));
        // Diagonal onto an edge, where faces tie.
        send_word(make_word(-3 * one, -3 * one, 0, one, one, 0, -one, -one, -one, one, one, one));
        send_word(make_word(-3 * one, -3 * one, -3 * one, one, one, one,
                            -one, -one, -one, one, one, one));
        // Tiny direction and a far box: entry distance saturates.
        send_word(make_word(fmin, 0, 0, 1, 0, 0, fmax - one, -one, -one, fmax, one, one));
        // Field extremes.
        send_word(make_word(fmin, fmin, fmin, fmax, fmax, fmax,
                            fmax, fmax, fmax, fmin, fmin, fmin));
        send_word(make_word(fmax, fmax, fmax, fmin, fmin, fmin,
                            fmin, fmin, fmin, fmax, fmax, fmax));
        send_word(make_word(fmin, fmax, 0, fmax, fmin, 1,
                            fmax, fmin, fmin, fmax, fmax, fmax));
        send_word(make_word(-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0));
        // Degenerate box of a single point on the ray.
        send_word(make_word(0, 0, 0, one, one, one, one, one, one, one, one, one));
        drain();
        // With a threshold set, small direction components count as parallel.
        write_threshold(16'h8000);
        send_word(make_word(-5 * one, 0, 0, one, 16'h8000, -16'sh8000,
                            -one, -one, -one, one, one, one));
        send_word(make_word(-5 * one, 2 * one, 0, one, 16'h7FFF, 0,
                            -one, -one, -one, one, one, one));
        send_word(make_word(-5 * one, 2 * one, 0, one, 16'h8001, 0,
                            -one, -one, -one, one, one, one));
        drain();
    endtask

    task automatic test_random(int count, logic [15:0] thr, int s_idle, int k_idle);
        write_threshold(thr);
        src_idle = s_idle;
        snk_idle = k_idle;
        repeat (count)
            send_word(random_word());
        drain();
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic compare(string field, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        slab_hit_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (hits_due.size() == 0)
            begin
                $error("result word with no item outstanding");
                errors++;
            end
            else
            begin
                want = hits_due.pop_front();
                n_hits += want.hit;
                compare("hit", want.hit, result.hit);
                compare("entry_distance", want.entry, result.entry_distance);
                compare("hit_pos_x", want.pos[0], result.hit_pos_x);
                compare("hit_pos_y", want.pos[1], result.hit_pos_y);
                compare("hit_pos_z", want.pos[2], result.hit_pos_z);
                compare("face_code", want.face, result.face_code);
            end
        end
        result.ready <= ($urandom_range(99) >= snk_idle);
    end

    initial
    begin
        cfg.valid = 1'b0;
        cfg.parallel_threshold = '0;
        ray_box.valid = 1'b0;
        {ray_box.origin_x, ray_box.origin_y, ray_box.origin_z} = '0;
        {ray_box.dir_x, ray_box.dir_y, ray_box.dir_z} = '0;
        {ray_box.corner_a_x, ray_box.corner_a_y, ray_box.corner_a_z} = '0;
        {ray_box.corner_b_x, ray_box.corner_b_y, ray_box.corner_b_z} = '0;
        result.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(170, 16'hFFFF, 18, 68);
        test_random(170, 16'($urandom_range(16'hFFFF)), 68, 18);
        test_random(170, 16'h0000, 0, 0);
        $display("Sent %0d ray/box words over four threshold settings, %0d of them hits.",
                 n_items, n_hits);
        if (errors == 0 && hits_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
